/* src/cte_pkg.sv */
package cte_pkg;

  // Default screen geometry
  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  // Fixed field widths
  localparam int CFG_ROW_W = 5;
  localparam int CFG_IDX_W = 2;
  localparam int OP_W      = 4;
  localparam int COORD_W   = 11;
  localparam int SRC_W     = 10;
  localparam int BOUND_W   = 8;

  // Command codes
  localparam logic [OP_W-1:0] OP_PUT     = 4'd0;
  localparam logic [OP_W-1:0] OP_CLEAR   = 4'd1;
  localparam logic [OP_W-1:0] OP_SETCUR  = 4'd2;
  localparam logic [OP_W-1:0] OP_FG      = 4'd3;
  localparam logic [OP_W-1:0] OP_BG      = 4'd4;
  localparam logic [OP_W-1:0] OP_FGDEF   = 4'd5;
  localparam logic [OP_W-1:0] OP_BGDEF   = 4'd6;
  localparam logic [OP_W-1:0] OP_SWAP    = 4'd7;
  localparam logic [OP_W-1:0] OP_SAVE    = 4'd8;
  localparam logic [OP_W-1:0] OP_RESTORE = 4'd9;
  localparam logic [OP_W-1:0] OP_UP      = 4'd10;
  localparam logic [OP_W-1:0] OP_DOWN    = 4'd11;
  localparam logic [OP_W-1:0] OP_MOVE    = 4'd12;
  localparam logic [OP_W-1:0] OP_READ    = 4'd13;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TOP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ON     = 2'd2;

  localparam logic [7:0] BLANK_CHAR = 8'h20;
  localparam logic [7:0] RESET_ATTR = 8'h07;
  localparam logic [2:0] DEF_FG     = 3'd7;

  // Scroll region as seen by the sequencer
  typedef struct packed {
    logic               ok;
    logic               on;
    logic [BOUND_W-1:0] top;
    logic [BOUND_W-1:0] bot;
  } cte_region_t;

  // ANSI to VGA colour order
  function automatic logic [2:0] ansi_color(input logic [2:0] c);
    logic [2:0] m;
    case (c)
      3'd0: m = 3'd0;
      3'd1: m = 3'd4;
      3'd2: m = 3'd2;
      3'd3: m = 3'd6;
      3'd4: m = 3'd1;
      3'd5: m = 3'd5;
      3'd6: m = 3'd3;
      default: m = 3'd7;
    endcase
    return m;
  endfunction

endpackage

/* src/cte_ram.sv */
module cte_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* src/cte_ctrl.sv */
module cte_ctrl import cte_pkg::*; #(
  parameter int TEXT_COLUMNS = DEF_COLUMNS,
  parameter int TEXT_ROWS    = DEF_ROWS,
  localparam int CW    = $clog2(TEXT_COLUMNS),
  localparam int RW    = $clog2(TEXT_ROWS),
  localparam int CELLS = TEXT_COLUMNS * TEXT_ROWS,
  localparam int AW    = $clog2(CELLS)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cte_region_t         region,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OP_W-1:0]     in_operation,
  input  logic [7:0]          in_char_code,
  input  logic [COORD_W-1:0]  in_col,
  input  logic [COORD_W-1:0]  in_row,
  input  logic [SRC_W-1:0]    in_src_col,
  input  logic [SRC_W-1:0]    in_src_row,
  input  logic [2:0]          in_color,
  input  logic                in_bright,
  input  logic                in_home_cursor,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [CW-1:0]       out_cursor_col,
  output logic [RW-1:0]       out_cursor_row,
  output logic [7:0]          out_attribute,
  output logic [7:0]          out_cell_char,
  output logic [7:0]          out_cell_attr,
  output logic                ram_we,
  output logic [AW-1:0]       ram_waddr,
  output logic [15:0]         ram_wdata,
  output logic [AW-1:0]       ram_raddr,
  input  logic [15:0]         ram_rdata
);

  localparam int AW1 = AW + 1;
  localparam logic [AW1-1:0] COLS_A   = AW1'(TEXT_COLUMNS);
  localparam logic [AW1-1:0] CELLS_A  = AW1'(CELLS);
  localparam logic [CW-1:0]  LAST_COL = CW'(TEXT_COLUMNS - 1);
  localparam logic [RW-1:0]  LAST_ROW = RW'(TEXT_ROWS - 1);

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] S_IDLE  = 4'd0;
  localparam logic [ST_W-1:0] S_FILL  = 4'd1;
  localparam logic [ST_W-1:0] S_CP_RD = 4'd2;
  localparam logic [ST_W-1:0] S_CP_WR = 4'd3;
  localparam logic [ST_W-1:0] S_MV_A  = 4'd4;
  localparam logic [ST_W-1:0] S_MV_B  = 4'd5;
  localparam logic [ST_W-1:0] S_MV_C  = 4'd6;
  localparam logic [ST_W-1:0] S_RD_A  = 4'd7;
  localparam logic [ST_W-1:0] S_RD_B  = 4'd8;

  logic [ST_W-1:0] state_r, state_nxt;
  logic [AW1-1:0]  addr_r, addr_nxt;
  logic [AW1-1:0]  aux_r, aux_nxt;
  logic [AW1-1:0]  fill_hi_r, fill_hi_nxt;
  logic            dir_up_r, dir_up_nxt;
  logic            init_r, init_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [CW-1:0]   cur_col_r, cur_col_nxt;
  logic [RW-1:0]   cur_row_r, cur_row_nxt;
  logic [7:0]      attr_r, attr_nxt;
  logic [CW-1:0]   sav_col_r, sav_col_nxt;
  logic [RW-1:0]   sav_row_r, sav_row_nxt;
  logic [7:0]      sav_attr_r, sav_attr_nxt;
  logic [7:0]      rd_char_r, rd_char_nxt;
  logic [7:0]      rd_attr_r, rd_attr_nxt;
  logic [7:0]      mv_char_r, mv_char_nxt;

  logic            accept;
  logic [AW1-1:0]  cur_addr, top_base, bot_base, rd_addr;
  logic [CW-1:0]   clamp_col;
  logic [RW-1:0]   clamp_row;
  logic            margin, move_ok;
  logic [2:0]      color_m;
  logic [15:0]     blank;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE) && !out_valid_r && !init_r;
  assign blank    = {attr_r, BLANK_CHAR};
  assign color_m  = ansi_color(in_color);

  // Cell addresses
  assign cur_addr = AW1'(cur_row_r) * COLS_A + AW1'(cur_col_r);
  assign top_base = AW1'(region.top) * COLS_A;
  assign bot_base = AW1'(region.bot) * COLS_A;

  // Coordinate clamping for setcur and read
  always_comb begin
    if (in_col[COORD_W-1]) begin
      clamp_col = '0;
    end else if (in_col >= COORD_W'(TEXT_COLUMNS)) begin
      clamp_col = LAST_COL;
    end else begin
      clamp_col = in_col[CW-1:0];
    end
    if (in_row[COORD_W-1]) begin
      clamp_row = '0;
    end else if (in_row >= COORD_W'(TEXT_ROWS)) begin
      clamp_row = LAST_ROW;
    end else begin
      clamp_row = in_row[RW-1:0];
    end
  end

  assign move_ok = !in_col[COORD_W-1] && (in_col < COORD_W'(TEXT_COLUMNS))
                && !in_row[COORD_W-1] && (in_row < COORD_W'(TEXT_ROWS))
                && (in_src_col < SRC_W'(TEXT_COLUMNS))
                && (in_src_row < SRC_W'(TEXT_ROWS));

  assign margin = region.ok && (BOUND_W'(cur_row_r) == region.bot - 8'd1)
               && (cur_col_r == LAST_COL);

  // Read port address
  always_comb begin
    case (state_r)
      S_CP_RD: rd_addr = dir_up_r ? addr_r + COLS_A : addr_r - COLS_A;
      S_MV_A:  rd_addr = aux_r;
      default: rd_addr = addr_r;
    endcase
  end
  assign ram_raddr = rd_addr[AW-1:0];

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    aux_nxt       = aux_r;
    fill_hi_nxt   = fill_hi_r;
    dir_up_nxt    = dir_up_r;
    init_nxt      = init_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cur_col_nxt   = cur_col_r;
    cur_row_nxt   = cur_row_r;
    attr_nxt      = attr_r;
    sav_col_nxt   = sav_col_r;
    sav_row_nxt   = sav_row_r;
    sav_attr_nxt  = sav_attr_r;
    rd_char_nxt   = rd_char_r;
    rd_attr_nxt   = rd_attr_r;
    mv_char_nxt   = mv_char_r;
    ram_we        = 1'b0;
    ram_waddr     = addr_r[AW-1:0];
    ram_wdata     = blank;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          rd_char_nxt   = '0;
          rd_attr_nxt   = '0;
          out_valid_nxt = 1'b1;
          case (in_operation)
            OP_PUT: begin
              ram_we    = 1'b1;
              ram_waddr = cur_addr[AW-1:0];
              ram_wdata = {attr_r, in_char_code};
              if (margin) begin
                if (region.on) begin
                  cur_col_nxt   = '0;
                  addr_nxt      = top_base;
                  aux_nxt       = bot_base - COLS_A;
                  fill_hi_nxt   = bot_base;
                  dir_up_nxt    = 1'b1;
                  state_nxt     = S_CP_RD;
                  out_valid_nxt = 1'b0;
                end
              end else if (cur_col_r == LAST_COL) begin
                cur_col_nxt = '0;
                if (cur_row_r != LAST_ROW) begin
                  cur_row_nxt = cur_row_r + 1'b1;
                end
              end else begin
                cur_col_nxt = cur_col_r + 1'b1;
              end
            end
            OP_CLEAR: begin
              addr_nxt      = '0;
              fill_hi_nxt   = CELLS_A;
              state_nxt     = S_FILL;
              out_valid_nxt = 1'b0;
              if (in_home_cursor) begin
                cur_col_nxt = '0;
                cur_row_nxt = '0;
              end
            end
            OP_SETCUR: begin
              cur_col_nxt = clamp_col;
              cur_row_nxt = clamp_row;
            end
            OP_FG:    attr_nxt = {attr_r[7:4], in_bright, color_m};
            OP_BG:    attr_nxt = {in_bright, color_m, attr_r[3:0]};
            OP_FGDEF: attr_nxt = {attr_r[7:4], in_bright, DEF_FG};
            OP_BGDEF: attr_nxt = {in_bright, 3'd0, attr_r[3:0]};
            OP_SWAP:  attr_nxt = {attr_r[3:0], attr_r[7:4]};
            OP_SAVE: begin
              sav_col_nxt  = cur_col_r;
              sav_row_nxt  = cur_row_r;
              sav_attr_nxt = attr_r;
            end
            OP_RESTORE: begin
              cur_col_nxt = sav_col_r;
              cur_row_nxt = sav_row_r;
              attr_nxt    = sav_attr_r;
            end
            OP_UP: begin
              if (region.ok) begin
                addr_nxt      = top_base;
                aux_nxt       = bot_base - COLS_A;
                fill_hi_nxt   = bot_base;
                dir_up_nxt    = 1'b1;
                state_nxt     = S_CP_RD;
                out_valid_nxt = 1'b0;
              end
            end
            OP_DOWN: begin
              if (region.ok) begin
                addr_nxt      = bot_base - 1'b1;
                aux_nxt       = top_base + COLS_A;
                fill_hi_nxt   = top_base + COLS_A;
                dir_up_nxt    = 1'b0;
                state_nxt     = S_CP_RD;
                out_valid_nxt = 1'b0;
              end
            end
            OP_MOVE: begin
              if (move_ok) begin
                aux_nxt = AW1'(in_src_row) * COLS_A + AW1'(in_src_col);
                addr_nxt = AW1'(in_row[RW-1:0]) * COLS_A + AW1'(in_col[CW-1:0]);
                state_nxt     = S_MV_A;
                out_valid_nxt = 1'b0;
              end
            end
            OP_READ: begin
              addr_nxt      = AW1'(clamp_row) * COLS_A + AW1'(clamp_col);
              state_nxt     = S_RD_A;
              out_valid_nxt = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      // Row copy: read the neighbor row cell, then write it one row over
      S_CP_RD: begin
        if (dir_up_r ? (addr_r < aux_r) : (addr_r >= aux_r)) begin
          state_nxt = S_CP_WR;
        end else begin
          addr_nxt  = dir_up_r ? aux_r : aux_r - COLS_A;
          state_nxt = S_FILL;
        end
      end
      S_CP_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        addr_nxt  = dir_up_r ? addr_r + 1'b1 : addr_r - 1'b1;
        state_nxt = S_CP_RD;
      end
      // Blank fill up to fill_hi
      S_FILL: begin
        ram_we   = 1'b1;
        addr_nxt = addr_r + 1'b1;
        if (addr_r == fill_hi_r - 1'b1) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = !init_r;
          init_nxt      = 1'b0;
        end
      end
      S_MV_A: state_nxt = S_MV_B;
      S_MV_B: begin
        mv_char_nxt = ram_rdata[7:0];
        state_nxt   = S_MV_C;
      end
      S_MV_C: begin
        ram_we        = 1'b1;
        ram_wdata     = {ram_rdata[15:8], mv_char_r};
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
      end
      S_RD_A: state_nxt = S_RD_B;
      S_RD_B: begin
        rd_char_nxt   = ram_rdata[7:0];
        rd_attr_nxt   = ram_rdata[15:8];
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state; reset starts the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FILL;
      addr_r      <= '0;
      fill_hi_r   <= CELLS_A;
      init_r      <= 1'b1;
      out_valid_r <= 1'b0;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      attr_r      <= RESET_ATTR;
      sav_col_r   <= '0;
      sav_row_r   <= '0;
      sav_attr_r  <= RESET_ATTR;
      rd_char_r   <= '0;
      rd_attr_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      fill_hi_r   <= fill_hi_nxt;
      init_r      <= init_nxt;
      out_valid_r <= out_valid_nxt;
      cur_col_r   <= cur_col_nxt;
      cur_row_r   <= cur_row_nxt;
      attr_r      <= attr_nxt;
      sav_col_r   <= sav_col_nxt;
      sav_row_r   <= sav_row_nxt;
      sav_attr_r  <= sav_attr_nxt;
      rd_char_r   <= rd_char_nxt;
      rd_attr_r   <= rd_attr_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    aux_r     <= aux_nxt;
    dir_up_r  <= dir_up_nxt;
    mv_char_r <= mv_char_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_cursor_col = cur_col_r;
  assign out_cursor_row = cur_row_r;
  assign out_attribute  = attr_r;
  assign out_cell_char  = rd_char_r;
  assign out_cell_attr  = rd_attr_r;

endmodule

/* src/text_console_cell_engine_top.sv */
// Channel | Direction | Handshake            | Payload
// in_     | input     | in_valid / in_ready   | operation, char_code, col, row, src_col,
//         |           |                       | src_row, color, bright, home_cursor
// out_    | output    | out_valid / out_ready | cursor_col, cursor_row, attribute,
//         |           |                       | cell_char, cell_attr
// cfg_    | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Cursor, attribute, setcur, save and restore commands, and put unless it scrolls, finish
// without leaving the idle state. Read steps through S_RD_A and S_RD_B, move through S_MV_A,
// S_MV_B and S_MV_C. Scroll and put-with-scroll copy the (region rows - 1) x columns cells by
// a read (S_CP_RD) and a write (S_CP_WR) each, then blank one row in S_FILL; clear blanks
// every cell in S_FILL. The cell RAM has one write port and one registered read port. After
// reset a clearing pass blanks all TEXT_COLUMNS*TEXT_ROWS cells (2000) before the first
// request is taken. in_ready is low while a command runs or a result waits.
module text_console_cell_engine_top import cte_pkg::*; #(
  parameter int TEXT_COLUMNS = DEF_COLUMNS,
  parameter int TEXT_ROWS    = DEF_ROWS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [OP_W-1:0]               in_operation,
  input  logic [7:0]                    in_char_code,
  input  logic [COORD_W-1:0]            in_col,
  input  logic [COORD_W-1:0]            in_row,
  input  logic [SRC_W-1:0]              in_src_col,
  input  logic [SRC_W-1:0]              in_src_row,
  input  logic [2:0]                    in_color,
  input  logic                          in_bright,
  input  logic                          in_home_cursor,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [$clog2(TEXT_COLUMNS)-1:0] out_cursor_col,
  output logic [$clog2(TEXT_ROWS)-1:0]  out_cursor_row,
  output logic [7:0]                    out_attribute,
  output logic [7:0]                    out_cell_char,
  output logic [7:0]                    out_cell_attr,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_ROW_W-1:0]          cfg_data
);

  localparam int CELLS = TEXT_COLUMNS * TEXT_ROWS;
  localparam int AW    = $clog2(CELLS);

  logic [CFG_ROW_W-1:0] top_r, bot_r;
  logic                 on_r;
  logic [BOUND_W-1:0]   bot_ext;
  cte_region_t          region;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [15:0]          ram_wdata, ram_rdata;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r <= '0;
      bot_r <= CFG_ROW_W'(DEF_ROWS);
      on_r  <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TOP:    top_r <= cfg_data;
        REG_BOTTOM: bot_r <= cfg_data;
        REG_ON:     on_r  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Effective scroll region: bottom limited to the screen
  assign bot_ext    = BOUND_W'(bot_r);
  assign region.bot = (bot_ext > BOUND_W'(TEXT_ROWS)) ? BOUND_W'(TEXT_ROWS) : bot_ext;
  assign region.top = BOUND_W'(top_r);
  assign region.ok  = BOUND_W'(top_r) < region.bot;
  assign region.on  = on_r;

  cte_ctrl #(
    .TEXT_COLUMNS(TEXT_COLUMNS),
    .TEXT_ROWS   (TEXT_ROWS)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .region        (region),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_operation  (in_operation),
    .in_char_code  (in_char_code),
    .in_col        (in_col),
    .in_row        (in_row),
    .in_src_col    (in_src_col),
    .in_src_row    (in_src_row),
    .in_color      (in_color),
    .in_bright     (in_bright),
    .in_home_cursor(in_home_cursor),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_cursor_col(out_cursor_col),
    .out_cursor_row(out_cursor_row),
    .out_attribute (out_attribute),
    .out_cell_char (out_cell_char),
    .out_cell_attr (out_cell_attr),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata)
  );

  cte_ram #(
    .WIDTH(16),
    .DEPTH(CELLS)
  ) u_cells (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

endmodule
